// ----- sv/tcgr_pkg.sv -----
// Shared types and constants of the text console glyph renderer.
`default_nettype none
package tcgr_pkg;

	localparam int COORD_W   = 13;
	localparam int CURY_W    = 16;
	localparam int ROWY_W    = 17;
	localparam int PROD_W    = 30;
	localparam int OFFSET_W  = 28;
	localparam int COLOR_W   = 32;
	localparam int MASK_W    = 8;
	localparam int CODE_W    = 8;
	localparam int ROW_W     = 4;
	localparam int PADDR_W   = 4;
	localparam int PDATA_W   = 32;
	localparam int STORE_MAX = 4096;

	localparam int ROWS_DRAWN  = 16;
	localparam int CELL_WIDTH  = 8;
	localparam int LINE_HEIGHT = 16;

	localparam logic [CODE_W-1:0] CODE_NUL     = 8'd0;
	localparam logic [CODE_W-1:0] CODE_NEWLINE = 8'd10;
	localparam logic [CODE_W-1:0] CODE_RETURN  = 8'd13;

	localparam logic OP_PRINT = 1'b0;
	localparam logic OP_LOAD  = 1'b1;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_PITCH  = 2'd2;
	localparam logic [1:0] REG_COLOR  = 2'd3;

	localparam logic [COORD_W-1:0] RESET_WIDTH  = 13'd1024;
	localparam logic [COORD_W-1:0] RESET_HEIGHT = 13'd768;
	localparam logic [COORD_W-1:0] RESET_PITCH  = 13'd1024;
	localparam logic [COLOR_W-1:0] RESET_COLOR  = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [COORD_W-1:0] width;
		logic [COORD_W-1:0] height;
		logic [COORD_W-1:0] pitch;
		logic [COLOR_W-1:0] color;
	} cfg_t;

	typedef struct packed {
		logic               valid;
		logic               ok;
		logic               last;
		logic [ROWY_W-1:0]  y;
		logic [COORD_W-1:0] x;
	} row_req_t;

endpackage
`default_nettype wire

// ----- sv/tcgr_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none
module tcgr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- sv/tcgr_cfg.sv -----
// APB configuration registers of the text console glyph renderer.
`default_nettype none
module tcgr_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [tcgr_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [tcgr_pkg::PDATA_W-1:0]  pwdata,
	output logic      [tcgr_pkg::PDATA_W-1:0]  prdata,
	output logic                               pready,
	output tcgr_pkg::cfg_t                     cfg
);
	import tcgr_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= RESET_WIDTH;
			cfg_q.height <= RESET_HEIGHT;
			cfg_q.pitch  <= RESET_PITCH;
			cfg_q.color  <= RESET_COLOR;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_WIDTH:  cfg_q.width  <= pwdata[COORD_W-1:0];
				REG_HEIGHT: cfg_q.height <= pwdata[COORD_W-1:0];
				REG_PITCH:  cfg_q.pitch  <= pwdata[COORD_W-1:0];
				REG_COLOR:  cfg_q.color  <= pwdata[COLOR_W-1:0];
				default:    cfg_q.color  <= cfg_q.color;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_WIDTH:  prdata = PDATA_W'(cfg_q.width);
			REG_HEIGHT: prdata = PDATA_W'(cfg_q.height);
			REG_PITCH:  prdata = PDATA_W'(cfg_q.pitch);
			REG_COLOR:  prdata = PDATA_W'(cfg_q.color);
			default:    prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

// ----- sv/tcgr_row_unit.sv -----
// Shared row datapath: offset multiplier, clipping and the output register.
`default_nettype none
module tcgr_row_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire tcgr_pkg::row_req_t           req,
	input  wire tcgr_pkg::cfg_t               cfg,
	input  wire logic [tcgr_pkg::MASK_W-1:0]  rdata,
	output logic                              adv,
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	// pixel_offset[27:0], pixel_mask[35:28], pixel_color[67:36], zero pad[71:68]
	output logic      [71:0]                  m_tdata,
	output logic                              m_tlast
);
	import tcgr_pkg::*;

	logic                v_s1;
	logic [PROD_W-1:0]   prod_s1;
	logic                vis_s1;
	logic                ok_s1;
	logic                last_s1;
	logic [COORD_W-1:0]  x_s1;
	logic [MASK_W-1:0]   colmask_s1;
	logic [MASK_W-1:0]   colmask;

	logic                valid_q;
	logic [OFFSET_W-1:0] offset_q;
	logic [MASK_W-1:0]   mask_q;
	logic                last_q;

	assign adv = !valid_q || m_tready;

	always_comb begin
		for (int b = 0; b < CELL_WIDTH; b++) begin
			colmask[MASK_W-1-b] = ({1'b0, req.x} + (COORD_W+1)'(b)) < {1'b0, cfg.width};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			valid_q <= 1'b0;
		end else if (adv) begin
			v_s1    <= req.valid;
			valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1    <= PROD_W'(req.y) * PROD_W'(cfg.pitch);
			vis_s1     <= req.y < ROWY_W'(cfg.height);
			ok_s1      <= req.ok;
			last_s1    <= req.last;
			x_s1       <= req.x;
			colmask_s1 <= colmask;
			if (v_s1) begin
				offset_q <= prod_s1[OFFSET_W-1:0] + OFFSET_W'(x_s1);
				mask_q   <= (ok_s1 && vis_s1) ? (rdata & colmask_s1) : '0;
				last_q   <= last_s1;
			end
		end
	end

	assign m_tvalid = valid_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {4'b0000, cfg.color, mask_q, offset_q};

endmodule
`default_nettype wire

// ----- sv/text_console_glyph_renderer.sv -----
// Top level of the text console glyph renderer: sequencer, cursor and glyph store.
// The block takes one input beat at a time. A load, a control code or code zero
// is handled entirely when it is accepted. A printable code is accepted and then
// the sequencer steps the shared row unit through the sixteen glyph rows, with
// one glyph store read and one offset multiplication per row, and holds while
// the output side stalls; each row beat passes the row unit's first stage and
// its output register before it appears. The glyph store needs no clearing after
// reset; an entry must be loaded before any character that uses it is printed.
`default_nettype none
module text_console_glyph_renderer #(
	parameter int GLYPH_ROWS  = 16,
	parameter int GLYPH_COUNT = 256
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// char_code[7:0], glyph_row[11:8], glyph_bits[19:12], zero pad[23:20]
	input  wire logic [23:0]                   s_tdata,
	// opcode[0]
	input  wire logic                          s_tuser,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// pixel_offset[27:0], pixel_mask[35:28], pixel_color[67:36], zero pad[71:68]
	output logic      [71:0]                   m_tdata,
	output logic                               m_tlast,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [tcgr_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [tcgr_pkg::PDATA_W-1:0]  pwdata,
	output logic      [tcgr_pkg::PDATA_W-1:0]  prdata,
	output logic                               pready
);
	import tcgr_pkg::*;

	localparam int STORE_LIMIT = (GLYPH_COUNT * GLYPH_ROWS < STORE_MAX) ?
		GLYPH_COUNT * GLYPH_ROWS : STORE_MAX;
	localparam int RAM_AW = $clog2(STORE_LIMIT);
	localparam int ADDR_W = $clog2((1 << CODE_W) * GLYPH_ROWS + ROWS_DRAWN);

	typedef enum logic {
		ST_IDLE,
		ST_ROWS
	} state_t;

	state_t              state_q;
	logic [COORD_W-1:0]  cur_x_q;
	logic [CURY_W-1:0]   cur_y_q;
	logic [COORD_W-1:0]  chx_q;
	logic [CURY_W-1:0]   chy_q;
	logic [ADDR_W-1:0]   base_q;
	logic [ROW_W-1:0]    row_q;

	cfg_t                cfg;
	row_req_t            req;
	logic                adv;
	logic                in_acc;
	logic                opcode;
	logic [CODE_W-1:0]   char_code;
	logic [ROW_W-1:0]    glyph_row;
	logic [MASK_W-1:0]   glyph_bits;
	logic [ADDR_W-1:0]   load_addr;
	logic [ADDR_W-1:0]   row_addr;
	logic                ram_we;
	logic                ram_re;
	logic [MASK_W-1:0]   ram_rdata;
	logic [COORD_W+1:0]  next_x;
	logic                wrap;
	logic [CURY_W:0]     y_sum;
	logic [CURY_W-1:0]   y_line;

	assign s_tready   = (state_q == ST_IDLE);
	assign in_acc     = s_tvalid && s_tready;
	assign opcode     = s_tuser;
	assign char_code  = s_tdata[7:0];
	assign glyph_row  = s_tdata[11:8];
	assign glyph_bits = s_tdata[19:12];

	assign load_addr = ADDR_W'(char_code) * ADDR_W'(GLYPH_ROWS) + ADDR_W'(glyph_row);
	assign ram_we    = in_acc && (opcode == OP_LOAD) && (load_addr < ADDR_W'(STORE_LIMIT));

	assign row_addr  = base_q + ADDR_W'(row_q);
	assign req.valid = (state_q == ST_ROWS);
	assign req.ok    = row_addr < ADDR_W'(STORE_LIMIT);
	assign req.last  = row_q == ROW_W'(ROWS_DRAWN - 1);
	assign req.y     = ROWY_W'(chy_q) + ROWY_W'(row_q);
	assign req.x     = chx_q;
	assign ram_re    = req.valid && req.ok && adv;

	assign next_x = {2'b00, cur_x_q} + (COORD_W+2)'(CELL_WIDTH);
	assign wrap   = (next_x + (COORD_W+2)'(CELL_WIDTH)) > {2'b00, cfg.width};
	assign y_sum  = {1'b0, cur_y_q} + (CURY_W+1)'(LINE_HEIGHT);
	assign y_line = y_sum[CURY_W] ? '1 : y_sum[CURY_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cur_x_q <= '0;
			cur_y_q <= '0;
			chx_q   <= '0;
			chy_q   <= '0;
			base_q  <= '0;
			row_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && (opcode == OP_PRINT)) begin
						priority if (char_code == CODE_NUL) begin
							cur_x_q <= cur_x_q;
						end else if (char_code == CODE_NEWLINE) begin
							cur_y_q <= y_line;
						end else if (char_code == CODE_RETURN) begin
							cur_x_q <= '0;
						end else begin
							chx_q   <= cur_x_q;
							chy_q   <= cur_y_q;
							base_q  <= ADDR_W'(char_code) * ADDR_W'(GLYPH_ROWS);
							row_q   <= '0;
							state_q <= ST_ROWS;
							if (wrap) begin
								cur_x_q <= '0;
								cur_y_q <= y_line;
							end else begin
								cur_x_q <= next_x[COORD_W-1:0];
							end
						end
					end
				end
				ST_ROWS: begin
					if (adv) begin
						row_q <= row_q + ROW_W'(1);
						if (req.last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	tcgr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tcgr_ram #(
		.WIDTH (MASK_W),
		.DEPTH (STORE_LIMIT)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (load_addr[RAM_AW-1:0]),
		.wdata (glyph_bits),
		.re    (ram_re),
		.raddr (row_addr[RAM_AW-1:0]),
		.rdata (ram_rdata)
	);

	tcgr_row_unit u_row (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cfg      (cfg),
		.rdata    (ram_rdata),
		.adv      (adv),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire

// ----- verif/tb.sv -----
// Testbench for the text console glyph renderer: drives glyph loads and character codes, predicts each row write and checks it.
module tb;
	import tcgr_pkg::*;

	localparam int GLYPH_ROWS   = 16;
	localparam int GLYPH_COUNT  = 256;
	localparam int DRAIN_CYCLES = 24;
	localparam int MAX_REPORTS  = 40;
	localparam int CURSOR_Y_MAX = 65535;
	localparam logic [MASK_W-1:0] LEFT_PIXEL = 8'h80;

	typedef struct {
		logic [OFFSET_W-1:0] offset;
		logic [MASK_W-1:0]   mask;
		logic [COLOR_W-1:0]  color;
		logic                last;
	} row_write_t;

	logic clk;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// char_code[7:0], glyph_row[11:8], glyph_bits[19:12], zero pad[23:20]
	logic [23:0] s_tdata = '0;
	// opcode[0]
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// pixel_offset[27:0], pixel_mask[35:28], pixel_color[67:36], zero pad[71:68]
	logic [71:0] m_tdata;
	logic m_tlast;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	int send_idle_pct = 13;
	int recv_stall_pct = 45;
	int error_count = 0;

	cfg_t shadow_cfg;
	int unsigned text_x;
	int unsigned text_y;
	logic [MASK_W-1:0] font_rows [STORE_MAX];
	row_write_t pending_rows [$];

	logic [15:0] rows_loaded [256];
	bit glyph_ready [256];
	logic [CODE_W-1:0] ready_codes [$];
	logic [CODE_W-1:0] control_codes [3] = '{CODE_NUL, CODE_NEWLINE, CODE_RETURN};

	text_console_glyph_renderer #(
		.GLYPH_ROWS(GLYPH_ROWS),
		.GLYPH_COUNT(GLYPH_COUNT)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic int unsigned font_limit();
		return (GLYPH_COUNT * GLYPH_ROWS < STORE_MAX) ? GLYPH_COUNT * GLYPH_ROWS : STORE_MAX;
	endfunction

	function automatic void next_text_line();
		text_y = (text_y + LINE_HEIGHT > CURSOR_Y_MAX) ? CURSOR_Y_MAX : text_y + LINE_HEIGHT;
	endfunction

	function automatic void draw_glyph(logic [CODE_W-1:0] code);
		int unsigned addr;
		int unsigned y;
		logic [MASK_W-1:0] bits;
		longint unsigned prod;
		row_write_t rw;
		for (int r = 0; r < ROWS_DRAWN; r++) begin
			addr = int'(code) * GLYPH_ROWS + r;
			bits = (addr < font_limit()) ? font_rows[addr] : '0;
			y = text_y + r;
			if (y >= shadow_cfg.height)
				bits = '0;
			for (int b = 0; b < CELL_WIDTH; b++)
				if (text_x + b >= shadow_cfg.width)
					bits &= ~(LEFT_PIXEL >> b);
			prod = longint'(y) * shadow_cfg.pitch + text_x;
			rw.offset = prod[OFFSET_W-1:0];
			rw.mask = bits;
			rw.color = shadow_cfg.color;
			rw.last = (r == ROWS_DRAWN - 1);
			pending_rows.push_back(rw);
		end
		text_x += CELL_WIDTH;
		if (text_x + CELL_WIDTH > shadow_cfg.width) begin
			text_x = 0;
			next_text_line();
		end
		text_x &= (1 << COORD_W) - 1;
	endfunction

	function automatic void model_beat(logic op, logic [CODE_W-1:0] code,
			logic [ROW_W-1:0] row, logic [MASK_W-1:0] bits);
		int unsigned addr;
		addr = int'(code) * GLYPH_ROWS + row;
		if (op == OP_LOAD) begin
			if (addr < font_limit())
				font_rows[addr] = bits;
		end else if (code == CODE_NEWLINE) begin
			next_text_line();
		end else if (code == CODE_RETURN) begin
			text_x = 0;
		end else if (code != CODE_NUL) begin
			draw_glyph(code);
		end
	endfunction

	function automatic void apply_register(logic [1:0] idx, logic [PDATA_W-1:0] value);
		case (idx)
			REG_WIDTH:  shadow_cfg.width = value[COORD_W-1:0];
			REG_HEIGHT: shadow_cfg.height = value[COORD_W-1:0];
			REG_PITCH:  shadow_cfg.pitch = value[COORD_W-1:0];
			REG_COLOR:  shadow_cfg.color = value[COLOR_W-1:0];
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(string msg);
		if (error_count < MAX_REPORTS)
			$display("%0t mismatch: %s", $time, msg);
		error_count++;
	endtask

	task automatic check_row_beat();
		row_write_t want;
		if (pending_rows.size() == 0) begin
			report_mismatch($sformatf("row beat with none expected, tdata %h", m_tdata));
			return;
		end
		want = pending_rows.pop_front();
		if (m_tdata[27:0] !== want.offset)
			report_mismatch($sformatf("offset %h, expected %h", m_tdata[27:0], want.offset));
		if (m_tdata[35:28] !== want.mask)
			report_mismatch($sformatf("mask %h, expected %h", m_tdata[35:28], want.mask));
		if (m_tdata[67:36] !== want.color)
			report_mismatch($sformatf("color %h, expected %h", m_tdata[67:36], want.color));
		if (m_tlast !== want.last)
			report_mismatch($sformatf("tlast %b, expected %b", m_tlast, want.last));
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (psel && penable && pwrite && pready)
				apply_register(paddr[3:2], pwdata);
			if (s_tvalid && s_tready)
				model_beat(s_tuser, s_tdata[7:0], s_tdata[11:8], s_tdata[19:12]);
			if (m_tvalid && m_tready)
				check_row_beat();
		end
	end

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall_pct);

	task automatic send_beat(logic op, logic [CODE_W-1:0] code, logic [ROW_W-1:0] row,
			logic [MASK_W-1:0] bits);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {4'b0000, bits, row, code};
		do @(posedge clk); while (!s_tready);
		if (op == OP_LOAD) begin
			rows_loaded[code][row] = 1'b1;
			if (&rows_loaded[code] && !glyph_ready[code] && code != CODE_NUL &&
					code != CODE_NEWLINE && code != CODE_RETURN) begin
				glyph_ready[code] = 1'b1;
				ready_codes.push_back(code);
			end
		end
	endtask

	task automatic print_char(logic [CODE_W-1:0] code);
		send_beat(OP_PRINT, code, ROW_W'($urandom_range(15)), MASK_W'($urandom_range(255)));
	endtask

	task automatic load_glyph(logic [CODE_W-1:0] code, logic [MASK_W-1:0] fill, bit use_fill);
		for (int r = 0; r < GLYPH_ROWS; r++)
			send_beat(OP_LOAD, code, r[ROW_W-1:0],
				use_fill ? fill : MASK_W'($urandom_range(255)));
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_rows.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(logic [1:0] idx, logic [PDATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_screen(logic [COORD_W-1:0] w, logic [COORD_W-1:0] h,
			logic [COORD_W-1:0] p, logic [COLOR_W-1:0] color);
		write_register(REG_WIDTH, PDATA_W'(w));
		write_register(REG_HEIGHT, PDATA_W'(h));
		write_register(REG_PITCH, PDATA_W'(p));
		write_register(REG_COLOR, color);
	endtask

	task automatic test_font_load();
		load_glyph(8'hFF, 8'hFF, 1'b1);
		load_glyph(8'h01, 8'h00, 1'b1);
		load_glyph(8'h80, 8'h00, 1'b0);
		load_glyph(8'h55, 8'h00, 1'b0);
		send_beat(OP_LOAD, CODE_NEWLINE, 4'hF, 8'hA5);
	endtask

	task automatic test_print_controls();
		print_char(8'hFF);
		print_char(8'h01);
		print_char(8'h80);
		print_char(8'h55);
		send_beat(OP_PRINT, CODE_NUL, 4'h0, 8'h00);
		send_beat(OP_PRINT, CODE_RETURN, 4'h0, 8'h00);
		print_char(8'hFF);
		send_beat(OP_PRINT, CODE_NEWLINE, 4'h0, 8'h00);
		print_char(8'h80);
		send_beat(OP_PRINT, CODE_RETURN, 4'h0, 8'h00);
		print_char(8'h55);
		wait_idle();
	endtask

	// The cursor can only sit past the right edge when the width shrinks under it.
	task automatic test_clipping();
		send_beat(OP_PRINT, CODE_RETURN, 4'h0, 8'h00);
		print_char(8'hFF);
		print_char(8'hFF);
		wait_idle();
		set_screen(13'd20, COORD_W'(text_y + 5), 13'd4096, 32'h0000_0000);
		print_char(8'hFF);
		wait_idle();
		set_screen(13'd1, 13'd4096, 13'd1, 32'hFFFF_FFFF);
		print_char(8'hFF);
		print_char(8'h55);
		wait_idle();
	endtask

	task automatic test_random_traffic(int unsigned count);
		int unsigned sent;
		int unsigned pick;
		logic [CODE_W-1:0] code;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(99);
			if (pick < 12) begin
				do code = CODE_W'($urandom_range(255, 1));
				while (code == CODE_NEWLINE || code == CODE_RETURN);
				load_glyph(code, 8'h00, 1'b0);
				print_char(code);
				sent += GLYPH_ROWS + 1;
			end else if (pick < 24) begin
				send_beat(OP_LOAD, CODE_W'($urandom_range(255)), ROW_W'($urandom_range(15)),
					MASK_W'($urandom_range(255)));
				sent++;
			end else if (pick < 32) begin
				send_beat(OP_PRINT, control_codes[$urandom_range(2)],
					ROW_W'($urandom_range(15)), MASK_W'($urandom_range(255)));
				sent++;
			end else begin
				print_char(ready_codes[$urandom_range(ready_codes.size() - 1)]);
				sent++;
			end
		end
		wait_idle();
	endtask

	// New lines push the cursor far below a one-line screen, so every row is clipped.
	task automatic test_new_lines();
		repeat (40)
			send_beat(OP_PRINT, CODE_NEWLINE, ROW_W'($urandom_range(15)),
				MASK_W'($urandom_range(255)));
		wait_idle();
		set_screen(13'd4096, 13'd1, 13'd4096, 32'hA5A5_5A5A);
		send_beat(OP_PRINT, CODE_RETURN, 4'h0, 8'h00);
		print_char(8'hFF);
		print_char(8'h55);
		send_beat(OP_PRINT, CODE_NEWLINE, 4'h0, 8'h00);
		print_char(8'h80);
		wait_idle();
	endtask

	initial begin
		shadow_cfg.width = RESET_WIDTH;
		shadow_cfg.height = RESET_HEIGHT;
		shadow_cfg.pitch = RESET_PITCH;
		shadow_cfg.color = RESET_COLOR;
		text_x = 0;
		text_y = 0;
		foreach (rows_loaded[i])
			rows_loaded[i] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_font_load();
		test_print_controls();
		test_clipping();

		set_screen(13'd4096, 13'd4096, 13'd4096, $urandom);
		test_random_traffic(60);

		send_idle_pct = 45;
		recv_stall_pct = 13;
		set_screen(COORD_W'($urandom_range(1024, 64)), COORD_W'($urandom_range(4096, 1024)),
			COORD_W'($urandom_range(4096, 1)), $urandom);
		test_random_traffic(60);

		send_idle_pct = 0;
		recv_stall_pct = 0;
		set_screen(COORD_W'($urandom_range(200, 1)), 13'd4096,
			COORD_W'($urandom_range(4096, 1)), 32'h0000_0000);
		test_random_traffic(60);

		test_new_lines();

		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/tcgr_pkg.sv
sv/tcgr_ram.sv
sv/tcgr_cfg.sv
sv/tcgr_row_unit.sv
sv/text_console_glyph_renderer.sv
verif/tb.sv
